>>> sv/isml_pkg.sv
// Package for the interval set merge and lookup unit.
// Holds transaction types, function and status codes, and controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package isml_pkg;

  localparam int MAX_RANGES_DEF = 16;
  localparam int ADDR_WIDTH_DEF = 64;

  localparam logic       FUNC_INSERT    = 1'b0;
  localparam logic       FUNC_LOOKUP    = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_INVALID = 2'd2;

  typedef struct packed {
    logic        func;
    logic [63:0] range_low;
    logic [63:0] range_high;
  } isml_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        hit;
    logic [63:0] found_low;
    logic [63:0] found_high;
  } isml_out_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic commit;
  } isml_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic out_free;
  } isml_sts_t;

endpackage

`default_nettype wire

>>> sv/isml_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module isml_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

>>> sv/isml_ctrl.sv
// Controller state machine: accept, scan the table, commit and hand off the result.
// Depends on isml_pkg.
`timescale 1ns / 1ps
`default_nettype none

module isml_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output isml_pkg::isml_cmd_t      cmd,
  input  wire isml_pkg::isml_sts_t sts
);
  import isml_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_LAST,
    S_COMMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall   = (state_r != S_IDLE);
  assign cmd.load   = (state_r == S_IDLE) && in_valid;
  assign cmd.rd_en  = (state_r == S_SCAN);
  assign cmd.commit = (state_r == S_COMMIT) && sts.out_free;

endmodule

`default_nettype wire

>>> sv/isml_dp.sv
// Datapath: range table, compare and merge stage, result register.
// Depends on isml_pkg and isml_ram.
`timescale 1ns / 1ps
`default_nettype none

module isml_dp #(
  parameter int MAX_RANGES = isml_pkg::MAX_RANGES_DEF,
  parameter int ADDR_WIDTH = isml_pkg::ADDR_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire isml_pkg::isml_in_t   in_data,
  input  wire isml_pkg::isml_cmd_t  cmd,
  output isml_pkg::isml_sts_t       sts,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output isml_pkg::isml_out_t       out_data
);
  import isml_pkg::*;

  localparam int IDX_W = $clog2(MAX_RANGES);
  localparam int AW    = ADDR_WIDTH;

  logic             op_r, inv_r;
  logic [AW-1:0]    lo_r, hi_r;
  logic [IDX_W-1:0] addr_r;
  logic             cmp_vld_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic [MAX_RANGES-1:0] valid_r, valid_nxt;

  logic             merged_r, free_found_r, hit_r;
  logic [IDX_W-1:0] free_idx_r;
  logic [AW-1:0]    nlo_r, nhi_r, hit_lo_r, hit_hi_r;

  logic             out_valid_r;
  isml_out_t        out_data_r, out_nxt;

  logic [2*AW-1:0]  rd_data;
  logic [AW-1:0]    ent_lo, ent_hi, in_lo, in_hi;
  logic             ent_v, touch, in_hit, slot_free, do_write;

  isml_ram #(
    .WIDTH(2 * AW),
    .DEPTH(MAX_RANGES)
  ) u_table (
    .clk  (clk),
    .we   (do_write),
    .waddr(free_idx_r),
    .wdata({nhi_r, nlo_r}),
    .re   (cmd.rd_en),
    .raddr(addr_r),
    .rdata(rd_data)
  );

  assign in_lo  = in_data.range_low[AW-1:0];
  assign in_hi  = in_data.range_high[AW-1:0];
  assign ent_lo = rd_data[AW-1:0];
  assign ent_hi = rd_data[2*AW-1:AW];

  assign ent_v     = cmp_vld_r && valid_r[cmp_idx_r];
  assign touch     = ent_v && (op_r == FUNC_INSERT) && !inv_r
                     && (ent_lo <= hi_r) && (ent_hi >= lo_r);
  assign in_hit    = ent_v && (op_r == FUNC_LOOKUP) && (ent_lo <= lo_r) && (lo_r < ent_hi);
  assign slot_free = cmp_vld_r && (!valid_r[cmp_idx_r] || touch);
  assign do_write  = cmd.commit && (op_r == FUNC_INSERT) && !inv_r
                     && (merged_r || free_found_r);

  assign sts.scan_last = (addr_r == IDX_W'(MAX_RANGES - 1));
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (touch) begin
      valid_nxt[cmp_idx_r] = 1'b0;
    end
    if (do_write) begin
      valid_nxt[free_idx_r] = 1'b1;
    end
  end

  always_comb begin
    out_nxt = '0;
    if (op_r == FUNC_LOOKUP) begin
      out_nxt.status = STATUS_OK;
      if (hit_r) begin
        out_nxt.hit        = 1'b1;
        out_nxt.found_low  = 64'(hit_lo_r);
        out_nxt.found_high = 64'(hit_hi_r);
      end
    end else if (inv_r) begin
      out_nxt.status = STATUS_INVALID;
    end else if (!merged_r && !free_found_r) begin
      out_nxt.status = STATUS_FULL;
    end else begin
      out_nxt.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r   <= valid_nxt;
      cmp_vld_r <= cmd.rd_en;
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= addr_r;
    if (cmd.load) begin
      op_r         <= in_data.func;
      lo_r         <= in_lo;
      hi_r         <= in_hi;
      inv_r        <= (in_data.func == FUNC_INSERT) && (in_hi < in_lo);
      addr_r       <= '0;
      merged_r     <= 1'b0;
      free_found_r <= 1'b0;
      hit_r        <= 1'b0;
      nlo_r        <= in_lo;
      nhi_r        <= in_hi;
    end else begin
      if (cmd.rd_en) begin
        addr_r <= addr_r + 1'b1;
      end
      if (touch) begin
        merged_r <= 1'b1;
        if (ent_lo < nlo_r) begin
          nlo_r <= ent_lo;
        end
        if (ent_hi > nhi_r) begin
          nhi_r <= ent_hi;
        end
      end
      if (slot_free && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= cmp_idx_r;
      end
      if (in_hit && !hit_r) begin
        hit_r    <= 1'b1;
        hit_lo_r <= ent_lo;
        hit_hi_r <= ent_hi;
      end
    end
    if (cmd.commit) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

>>> sv/interval_set_merge_lookup_unit.sv
// Interval set merge and lookup unit: top level.
// A transaction is loaded from idle, scans the table, then commits its result once the output is free.
// A new transaction is stalled until the last one commits; the table scan reads one entry per cycle
// through the single read port of the range memory.
// Reset: synchronous, active low; clears all entry valid bits and the result valid flag.
// Depends on isml_pkg, isml_ctrl, isml_dp and isml_ram.
`timescale 1ns / 1ps
`default_nettype none

module interval_set_merge_lookup_unit #(
  parameter int MAX_RANGES = isml_pkg::MAX_RANGES_DEF,
  parameter int ADDR_WIDTH = isml_pkg::ADDR_WIDTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire isml_pkg::isml_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output isml_pkg::isml_out_t      out_data
);
  import isml_pkg::*;

  isml_cmd_t cmd;
  isml_sts_t sts;

  isml_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd     (cmd),
    .sts     (sts)
  );

  isml_dp #(
    .MAX_RANGES(MAX_RANGES),
    .ADDR_WIDTH(ADDR_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
